/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/pse_pkg.sv */
// Types, codes and helpers for the postfix stack evaluator.
// Depends on nothing; used by the controller, datapath and top level.
package pse_pkg;

   localparam logic [2:0] CMD_OPERAND = 3'd0;
   localparam logic [2:0] CMD_ADD     = 3'd1;
   localparam logic [2:0] CMD_SUB     = 3'd2;
   localparam logic [2:0] CMD_MUL     = 3'd3;
   localparam logic [2:0] CMD_DIV     = 3'd4;

   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_DIVZERO   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic {
      RD_TOP  = 1'b0,
      RD_NEXT = 1'b1
   } rd_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH_R,
      S_FETCH_L,
      S_CALC,
      S_ROUND,
      S_DIV,
      S_WRITE,
      S_TOP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       tok_load;
      logic       push;
      logic       set_err;
      status_type err_code;
      rd_sel_type rd_sel;
      logic       cap_right;
      logic       cap_left;
      logic       calc;
      logic       mul_round;
      logic       div_start;
      logic       div_take;
      logic       write_result;
      logic       resp_load;
      logic       clear_expr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] tok_cmd;
      logic       tok_last;
      logic       err_set;
      logic       full;
      logic       under;
      logic       count_zero;
      logic       div_zero;
      logic       div_done;
      logic       out_free;
   } dp_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/pse_divider.sv */
// Radix-2 restoring divider: (dividend * 2^FRAC_BITS) / divisor, truncated toward zero.
// Depends on nothing; one quotient bit per cycle, 32+FRAC_BITS steps.
module pse_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [31:0]        dividend,
   input  logic signed [31:0]        divisor,
   output logic signed [32+FRAC_BITS:0] quotient,
   output logic                      done
);

   localparam int QW   = 32 + FRAC_BITS;
   localparam int CNTW = $clog2(QW + 1);

   logic            busy_ff, busy_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [31:0]     rem_ff;
   logic [QW-1:0]   quo_ff;
   logic [31:0]     den_ff;
   logic            neg_ff;

   logic [31:0]     a_mag, b_mag;
   logic [32:0]     rem_sh, rem_nx;
   logic            ge;
   logic [QW:0]     mag_ext;

   assign a_mag = dividend[31] ? (~dividend + 32'd1) : dividend;
   assign b_mag = divisor[31]  ? (~divisor + 32'd1)  : divisor;

   // One shift-subtract step.
   assign rem_sh = {rem_ff, quo_ff[QW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign rem_nx = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;

   assign done    = busy_ff && (cnt_ff == '0);
   assign mag_ext = {1'b0, quo_ff};
   assign quotient = neg_ff ? -mag_ext : mag_ext;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(QW);
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= QW'(a_mag) << FRAC_BITS;
         den_ff <= b_mag;
         neg_ff <= dividend[31] ^ divisor[31];
      end else if (busy_ff && (cnt_ff != '0)) begin
         rem_ff <= rem_nx[31:0];
         quo_ff <= {quo_ff[QW-2:0], ge};
      end
   end

endmodule

/* rtl/pse_datapath.sv */
// Datapath: token register, stack memory, count and error latch, ALU and result beat.
// Depends on pse_pkg and pse_divider; steered by pse_ctrl commands.
module pse_datapath #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [2:0]             req_cmd,
   input  logic signed [31:0]     req_operand_value,
   input  logic                   req_last_token,
   input  pse_pkg::ctrl_cmd_type  cmd,
   output pse_pkg::dp_status_type stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_result_value,
   output logic [2:0]             rsp_status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int QW = 32 + FRAC_BITS;
   localparam logic signed [63:0] ROUND = (64'sd1 <<< FRAC_BITS) >>> 1;

   logic signed [31:0] mem [STACK_DEPTH];

   logic [2:0]          tok_cmd_ff;
   logic signed [31:0]  tok_operand_ff;
   logic                tok_last_ff;
   logic [CW-1:0]       count_ff, count_in;
   pse_pkg::status_type err_ff, err_in;
   logic signed [31:0]  rd_q_ff;
   logic signed [31:0]  right_ff, left_ff;
   logic signed [63:0]  prod_ff, wide_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_value_ff;
   pse_pkg::status_type rsp_status_ff;

   logic [CW-1:0]       top_idx, next_idx;
   logic [AW-1:0]       rd_addr;
   logic signed [31:0]  sat_value;
   logic signed [QW:0]  div_q;
   logic                div_done;
   logic signed [63:0]  left_ext, right_ext;
   logic                out_free;

   assign top_idx   = count_ff - CW'(1);
   assign next_idx  = count_ff - CW'(2);
   assign rd_addr   = (cmd.rd_sel == pse_pkg::RD_NEXT) ? next_idx[AW-1:0] : top_idx[AW-1:0];
   assign sat_value = pse_pkg::sat32(wide_ff);
   assign left_ext  = {{32{left_ff[31]}}, left_ff};
   assign right_ext = {{32{right_ff[31]}}, right_ff};
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   pse_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (left_ff),
      .divisor  (right_ff),
      .quotient (div_q),
      .done     (div_done)
   );

   // Stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[count_ff[AW-1:0]] <= tok_operand_ff;
      end else if (cmd.write_result) begin
         mem[next_idx[AW-1:0]] <= sat_value;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      if (cmd.clear_expr) begin
         count_in = '0;
         err_in   = pse_pkg::ST_OK;
      end else begin
         if (cmd.push) begin
            count_in = count_ff + CW'(1);
         end else if (cmd.write_result) begin
            count_in = top_idx;
         end
         if (cmd.set_err) begin
            err_in = cmd.err_code;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= pse_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tok_load) begin
         tok_cmd_ff     <= req_cmd;
         tok_operand_ff <= req_operand_value;
         tok_last_ff    <= req_last_token;
      end
      if (cmd.cap_right) begin
         right_ff <= rd_q_ff;
      end
      if (cmd.cap_left) begin
         left_ff <= rd_q_ff;
      end
      if (cmd.calc) begin
         case (tok_cmd_ff)
            pse_pkg::CMD_ADD: wide_ff <= left_ext + right_ext;
            pse_pkg::CMD_SUB: wide_ff <= left_ext - right_ext;
            pse_pkg::CMD_MUL: prod_ff <= left_ff * right_ff;
            default:          wide_ff <= '0;
         endcase
      end else if (cmd.mul_round) begin
         wide_ff <= (prod_ff + ROUND) >>> FRAC_BITS;
      end else if (cmd.div_take) begin
         wide_ff <= {{(63-QW){div_q[QW]}}, div_q};
      end
      if (cmd.resp_load) begin
         rsp_value_ff <= (count_ff == '0) ? 32'sd0 : rd_q_ff;
         if (err_ff != pse_pkg::ST_OK) begin
            rsp_status_ff <= err_ff;
         end else if (count_ff == '0) begin
            rsp_status_ff <= pse_pkg::ST_EMPTY;
         end else begin
            rsp_status_ff <= pse_pkg::ST_OK;
         end
      end
   end

   assign stat.tok_cmd    = tok_cmd_ff;
   assign stat.tok_last   = tok_last_ff;
   assign stat.err_set    = err_ff != pse_pkg::ST_OK;
   assign stat.full       = count_ff >= CW'(STACK_DEPTH);
   assign stat.under      = count_ff < CW'(2);
   assign stat.count_zero = count_ff == '0;
   assign stat.div_zero   = right_ff == 32'sd0;
   assign stat.div_done   = div_done;
   assign stat.out_free   = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* rtl/pse_ctrl.sv */
// Sequencer for the postfix stack evaluator: walks one token through fetch, compute, write.
// Depends on pse_pkg; drives pse_datapath through ctrl_cmd_type.
module pse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pse_pkg::dp_status_type stat,
   output pse_pkg::ctrl_cmd_type  cmd
);

   pse_pkg::state_type state_ff, state_in;
   pse_pkg::state_type after_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pse_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign after_tok = stat.tok_last ? pse_pkg::S_TOP : pse_pkg::S_IDLE;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         pse_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.tok_load = 1'b1;
               state_in     = pse_pkg::S_EXEC;
            end
         end
         pse_pkg::S_EXEC: begin
            if (stat.err_set || (stat.tok_cmd > pse_pkg::CMD_DIV)) begin
               state_in = after_tok;
            end else if (stat.tok_cmd == pse_pkg::CMD_OPERAND) begin
               if (stat.full) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = pse_pkg::ST_OVERFLOW;
               end else begin
                  cmd.push = 1'b1;
               end
               state_in = after_tok;
            end else if (stat.under) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = pse_pkg::ST_UNDERFLOW;
               state_in     = after_tok;
            end else begin
               cmd.rd_sel = pse_pkg::RD_TOP;
               state_in   = pse_pkg::S_FETCH_R;
            end
         end
         pse_pkg::S_FETCH_R: begin
            cmd.cap_right = 1'b1;
            cmd.rd_sel    = pse_pkg::RD_NEXT;
            state_in      = pse_pkg::S_FETCH_L;
         end
         pse_pkg::S_FETCH_L: begin
            cmd.cap_left = 1'b1;
            state_in     = pse_pkg::S_CALC;
         end
         pse_pkg::S_CALC: begin
            case (stat.tok_cmd)
               pse_pkg::CMD_MUL: begin
                  cmd.calc = 1'b1;
                  state_in = pse_pkg::S_ROUND;
               end
               pse_pkg::CMD_DIV: begin
                  if (stat.div_zero) begin
                     cmd.calc     = 1'b1;
                     cmd.set_err  = 1'b1;
                     cmd.err_code = pse_pkg::ST_DIVZERO;
                     state_in     = pse_pkg::S_WRITE;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = pse_pkg::S_DIV;
                  end
               end
               default: begin
                  cmd.calc = 1'b1;
                  state_in = pse_pkg::S_WRITE;
               end
            endcase
         end
         pse_pkg::S_ROUND: begin
            cmd.mul_round = 1'b1;
            state_in      = pse_pkg::S_WRITE;
         end
         pse_pkg::S_DIV: begin
            if (stat.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = pse_pkg::S_WRITE;
            end
         end
         pse_pkg::S_WRITE: begin
            cmd.write_result = 1'b1;
            state_in         = after_tok;
         end
         pse_pkg::S_TOP: begin
            cmd.rd_sel = pse_pkg::RD_TOP;
            state_in   = pse_pkg::S_RESP;
         end
         pse_pkg::S_RESP: begin
            cmd.rd_sel = pse_pkg::RD_TOP;
            if (stat.out_free) begin
               cmd.resp_load  = 1'b1;
               cmd.clear_expr = 1'b1;
               state_in       = pse_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pse_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/postfix_stack_evaluator.sv */
// Postfix stack evaluator: one token at a time, signed fixed point, bounded stack in a RAM.
// Each token is finished before the next is taken: an operand is pushed, an operator
// reads its operands, computes and writes back; at Q16.16 bit-serial divide is slowest.
// A last token also reads the top and loads the result beat, which waits out any rsp_stall.
// Synchronous active-high reset clears the sequencer, stack count, error latch and
// result valid; stack RAM contents are left as they are and never read before written.
`include "assert_macros.svh"

module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   // token channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_operand_value,
   input  logic               req_last_token,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [2:0]         rsp_status
);

   // Command bundle from the sequencer and status bundle back from the datapath.
   pse_pkg::ctrl_cmd_type  cmd;
   pse_pkg::dp_status_type stat;

   // Sequencer: takes a token beat in idle, then steps it through the stack
   // read, compute and write-back, and on the last token loads the result beat.
   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: holds the token, the stack RAM with its count, the first-error
   // latch, the adder/multiplier/divider and the registered result beat.
   pse_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_operand_value (req_operand_value),
      .req_last_token    (req_last_token),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status)
   );

   // Hold off the next token for at least the cycle after an accepted beat.
   `ASSERT_NEXT(a_one_token, clock, reset, req_valid && !req_stall, req_stall, "token accepted while busy")
   // Loading a result must leave a clean stack for the next expression.
   `ASSERT_NEXT(a_expr_clear, clock, reset, cmd.resp_load, stat.count_zero && !stat.err_set, "expression state not cleared")
   // Never push onto a full stack.
   `ASSERT_IMPLIES(a_no_push_full, clock, reset, cmd.push, !stat.full, "push on full stack")
   // Take the quotient only when the divider reports done.
   `ASSERT_IMPLIES(a_div_take, clock, reset, cmd.div_take, stat.div_done, "quotient taken early")

endmodule
